/* design/fasr_pkg.sv */
// fasr_pkg: shared types and codes for the fraction add/subtract/reduce unit
// holds the item structs, the sequencer state type and the operation/status codes
// no dependencies
package fasr_pkg;

    // operation codes (the unused code decodes as simplify)
    localparam logic [1:0] FUNC_ADD  = 2'd0;
    localparam logic [1:0] FUNC_SUB  = 2'd1;
    localparam logic [1:0] FUNC_SIMP = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_ZERO_DEN = 2'd1;
    localparam logic [1:0] STAT_OVF      = 2'd2;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic signed [63:0] res_den;
        logic [1:0]         status;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_ADD_FIN,
        ST_GCD,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_SIGN,
        ST_DONE
    } t_state;

endpackage

/* design/fasr_sub_unit.sv */
// fasr_sub_unit: the shared subtract/compare unit of the fraction unit
// gives the difference, the borrow (a < b) and an equality flag
// no package dependencies
module fasr_sub_unit #(
    parameter int WIDTH = 33
) (
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    output logic [WIDTH-1:0] o_diff,
    output logic             o_borrow,
    output logic             o_zero
);

    logic [WIDTH:0] w_full;

    assign w_full   = {1'b0, i_a} - {1'b0, i_b};
    assign o_diff   = w_full[WIDTH-1:0];
    assign o_borrow = w_full[WIDTH];
    assign o_zero   = (w_full[WIDTH-1:0] == '0);

endmodule

/* design/fraction_add_sub_reduce.sv */
// fraction_add_sub_reduce: rational add, subtract and gcd reduction
// uses fasr_pkg for item types and codes, and fasr_sub_unit for the shared subtractor
//
// usage
//   input channel: i_valid / o_stall with payload i_data (func, a_num, a_den, b_num, b_den)
//   output channel: o_valid / i_stall with payload o_data (res_num, res_den, status)
//   an item is taken when valid is high and stall is low at a rising edge
//   operands are the low OPERAND_WIDTH bits of each field, sign-extended
// timing
//   one item at a time: o_stall is high from the cycle after acceptance until the
//   result has been moved into the output register
//   add/subtract: the one shared signed multiplier forms the three products on
//   successive cycles, in ST_MUL_A, ST_MUL_B and ST_MUL_C
//   simplify: binary gcd on the shared subtractor, one step per cycle and
//   data dependent, then two restoring divisions on the same subtractor,
//   OPERAND_WIDTH quotient bits each, then the signs are applied in ST_SIGN
//   zero denominator and the trivial simplify cases go from ST_PREP straight to done
// reset and stall
//   synchronous active-low reset returns the sequencer to idle and empties the
//   output register; no other state is kept between items
//   a stalled result holds in the output register; the next item is still
//   accepted and worked on, and waits in the done state until the slot frees
module fraction_add_sub_reduce #(
    parameter int OPERAND_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  fasr_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output fasr_pkg::t_out_item o_data
);

    import fasr_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CW    = $clog2(W);
    localparam int PW    = 2 * W;
    localparam int SUM_W = 65;
    localparam int RW    = 64;

    // sequencer and item registers
    t_state               r_state, n_state;
    logic [1:0]           r_func, n_func;
    logic signed [W-1:0]  r_an, n_an;
    logic signed [W-1:0]  r_ad, n_ad;
    logic signed [W-1:0]  r_bn, n_bn;
    logic signed [W-1:0]  r_bd, n_bd;

    // gcd and divider working registers
    logic [W-1:0]         r_ma, n_ma;
    logic [W-1:0]         r_md, n_md;
    logic [W-1:0]         r_x, n_x;
    logic [W-1:0]         r_y, n_y;
    logic [CW-1:0]        r_k, n_k;
    logic [W-1:0]         r_g, n_g;
    logic [W-1:0]         r_dq, n_dq;
    logic [W-1:0]         r_rem, n_rem;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [W-1:0]         r_qa, n_qa;
    logic [W-1:0]         r_qd, n_qd;

    // multiplier products and the numerator sum
    logic signed [PW-1:0]    r_p1, n_p1;
    logic signed [PW-1:0]    r_p2, n_p2;
    logic signed [PW-1:0]    r_pd, n_pd;
    logic signed [SUM_W-1:0] r_sum, n_sum;

    // finished result and output slot
    logic signed [RW-1:0] r_res_num, n_res_num;
    logic signed [RW-1:0] r_res_den, n_res_den;
    logic [1:0]           r_res_stat, n_res_stat;
    logic                 r_ov_valid, n_ov_valid;
    t_out_item            r_odata, n_odata;

    // shared multiplier
    logic signed [W-1:0]  w_mul_a, w_mul_b;
    logic signed [PW-1:0] w_prod;

    // shared subtractor
    logic [W:0]           w_sub_a, w_sub_b, w_sub_diff;
    logic                 w_sub_borrow, w_sub_zero;

    logic [W:0]           w_shift_rem;
    logic                 w_qbit;
    logic                 w_is_addsub;

    assign w_prod = w_mul_a * w_mul_b;

    fasr_sub_unit #(
        .WIDTH(W + 1)
    ) u_sub (
        .i_a     (w_sub_a),
        .i_b     (w_sub_b),
        .o_diff  (w_sub_diff),
        .o_borrow(w_sub_borrow),
        .o_zero  (w_sub_zero)
    );

    assign w_shift_rem = {r_rem, r_dq[W-1]};
    assign w_qbit      = ~w_sub_borrow;
    assign w_is_addsub = (r_func == FUNC_ADD) || (r_func == FUNC_SUB);

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_ov_valid;
    assign o_data  = r_odata;

    // operand selection for the shared units
    always_comb begin
        w_mul_a = r_an;
        w_mul_b = r_bd;
        unique case (r_state)
            ST_MUL_B: begin
                w_mul_a = r_bn;
                w_mul_b = r_ad;
            end
            ST_MUL_C: begin
                w_mul_a = r_ad;
                w_mul_b = r_bd;
            end
            default: begin
                w_mul_a = r_an;
                w_mul_b = r_bd;
            end
        endcase

        unique case (r_state)
            ST_DIV_NUM, ST_DIV_DEN: begin
                w_sub_a = w_shift_rem;
                w_sub_b = {1'b0, r_g};
            end
            ST_GCD: begin
                w_sub_a = {1'b0, r_x};
                w_sub_b = {1'b0, r_y};
            end
            default: begin
                w_sub_a = {1'b0, r_ma};
                w_sub_b = {1'b0, r_md};
            end
        endcase
    end

    // next state and datapath
    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_an       = r_an;
        n_ad       = r_ad;
        n_bn       = r_bn;
        n_bd       = r_bd;
        n_ma       = r_ma;
        n_md       = r_md;
        n_x        = r_x;
        n_y        = r_y;
        n_k        = r_k;
        n_g        = r_g;
        n_dq       = r_dq;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        n_qa       = r_qa;
        n_qd       = r_qd;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_pd       = r_pd;
        n_sum      = r_sum;
        n_res_num  = r_res_num;
        n_res_den  = r_res_den;
        n_res_stat = r_res_stat;
        n_ov_valid = r_ov_valid & i_stall;
        n_odata    = r_odata;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_func  = i_data.func;
                    n_an    = i_data.a_num[W-1:0];
                    n_ad    = i_data.a_den[W-1:0];
                    n_bn    = i_data.b_num[W-1:0];
                    n_bd    = i_data.b_den[W-1:0];
                    n_state = ST_PREP;
                end
            end

            ST_PREP: begin
                n_ma = r_an[W-1] ? W'(-r_an) : W'(r_an);
                n_md = r_ad[W-1] ? W'(-r_ad) : W'(r_ad);
                if (w_is_addsub) begin
                    if ((r_ad == '0) || (r_bd == '0)) begin
                        n_res_num  = '0;
                        n_res_den  = '0;
                        n_res_stat = STAT_ZERO_DEN;
                        n_state    = ST_DONE;
                    end else begin
                        n_state = ST_MUL_A;
                    end
                end else if (r_ad == '0) begin
                    n_res_num  = '0;
                    n_res_den  = '0;
                    n_res_stat = STAT_ZERO_DEN;
                    n_state    = ST_DONE;
                end else if (r_an == '0) begin
                    n_res_num  = '0;
                    n_res_den  = RW'(1);
                    n_res_stat = STAT_OK;
                    n_state    = ST_DONE;
                end else if (n_ma == n_md) begin
                    // equal magnitudes: sign goes to the numerator only
                    n_res_num  = (r_an[W-1] != r_ad[W-1]) ? -RW'(1) : RW'(1);
                    n_res_den  = RW'(1);
                    n_res_stat = STAT_OK;
                    n_state    = ST_DONE;
                end else begin
                    n_x     = n_ma;
                    n_y     = n_md;
                    n_k     = '0;
                    n_state = ST_GCD;
                end
            end

            ST_MUL_A: begin
                n_p1    = w_prod;
                n_state = ST_MUL_B;
            end

            ST_MUL_B: begin
                n_p2    = w_prod;
                n_state = ST_MUL_C;
            end

            ST_MUL_C: begin
                n_pd = w_prod;
                if (r_func == FUNC_SUB) begin
                    n_sum = SUM_W'(r_p1) - SUM_W'(r_p2);
                end else begin
                    n_sum = SUM_W'(r_p1) + SUM_W'(r_p2);
                end
                n_state = ST_ADD_FIN;
            end

            ST_ADD_FIN: begin
                if (r_sum[SUM_W-1] != r_sum[SUM_W-2]) begin
                    n_res_num  = '0;
                    n_res_den  = '0;
                    n_res_stat = STAT_OVF;
                end else begin
                    n_res_num  = r_sum[RW-1:0];
                    n_res_den  = RW'(r_pd);
                    n_res_stat = STAT_OK;
                end
                n_state = ST_DONE;
            end

            ST_GCD: begin
                // binary gcd, one step per cycle
                if (w_sub_zero) begin
                    n_g     = r_x << r_k;
                    n_dq    = r_ma;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV_NUM;
                end else if (!r_x[0] && !r_y[0]) begin
                    n_x = r_x >> 1;
                    n_y = r_y >> 1;
                    n_k = r_k + CW'(1);
                end else if (!r_x[0]) begin
                    n_x = r_x >> 1;
                end else if (!r_y[0]) begin
                    n_y = r_y >> 1;
                end else if (!w_sub_borrow) begin
                    n_x = {1'b0, w_sub_diff[W-1:1]};
                end else begin
                    n_x = r_y;
                    n_y = r_x;
                end
            end

            ST_DIV_NUM, ST_DIV_DEN: begin
                // restoring division, one quotient bit per cycle
                n_rem = w_sub_borrow ? w_shift_rem[W-1:0] : w_sub_diff[W-1:0];
                n_dq  = {r_dq[W-2:0], w_qbit};
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    n_rem = '0;
                    n_cnt = '0;
                    if (r_state == ST_DIV_NUM) begin
                        n_qa    = {r_dq[W-2:0], w_qbit};
                        n_dq    = r_md;
                        n_state = ST_DIV_DEN;
                    end else begin
                        n_qd    = {r_dq[W-2:0], w_qbit};
                        n_state = ST_SIGN;
                    end
                end
            end

            ST_SIGN: begin
                n_res_num  = r_an[W-1] ? -RW'(r_qa) : RW'(r_qa);
                n_res_den  = r_ad[W-1] ? -RW'(r_qd) : RW'(r_qd);
                n_res_stat = STAT_OK;
                n_state    = ST_DONE;
            end

            ST_DONE: begin
                // wait for the output slot to free
                if (!r_ov_valid || !i_stall) begin
                    n_odata.res_num = r_res_num;
                    n_odata.res_den = r_res_den;
                    n_odata.status  = r_res_stat;
                    n_ov_valid      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ov_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ov_valid <= n_ov_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_an       <= n_an;
        r_ad       <= n_ad;
        r_bn       <= n_bn;
        r_bd       <= n_bd;
        r_ma       <= n_ma;
        r_md       <= n_md;
        r_x        <= n_x;
        r_y        <= n_y;
        r_k        <= n_k;
        r_g        <= n_g;
        r_dq       <= n_dq;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_qa       <= n_qa;
        r_qd       <= n_qd;
        r_p1       <= n_p1;
        r_p2       <= n_p2;
        r_pd       <= n_pd;
        r_sum      <= n_sum;
        r_res_num  <= n_res_num;
        r_res_den  <= n_res_den;
        r_res_stat <= n_res_stat;
        r_odata    <= n_odata;
    end

endmodule

/* dv/fraction_add_sub_reduce_tb.sv */
`timescale 1ns / 100ps
// fraction_add_sub_reduce_tb: self-checking bench for the rational add/sub/reduce unit
// depends on fasr_pkg (item structs, operation and status codes) and the block's RTL
// directed corner items first, then random traffic under several idle/stall mixes
module fraction_add_sub_reduce_tb;
    import fasr_pkg::*;

    // the spare selector value, decoded by the block as simplify
    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam int         TAIL_CYCLES = 300;
    localparam int         MAX_REPORTS = 10;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    // results the block still owes, oldest first
    t_out_item pending_results[$];
    t_out_item want;

    int idle_pct;
    int stall_pct;
    int mismatches;
    int results_seen;
    int items_sent;
    int simplify_sent;
    int zero_den_seen;
    int overflow_seen;
    int cycle_count;

    fraction_add_sub_reduce u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run-away guard: counts rising edges and gives up at the limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // receiver back-pressure, redrawn at every falling edge
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // expected result of one item: sums and differences stay unreduced,
    // simplify divides out the gcd of the magnitudes and keeps both signs
    function automatic t_out_item fraction_result(t_in_item it);
        logic signed [63:0] an, ad, bn, bd, p1, p2;
        logic signed [65:0] w1, w2, acc;
        logic [63:0]        mag_n, mag_d, x, y, t;
        t_out_item          r;
        an = it.a_num;
        ad = it.a_den;
        bn = it.b_num;
        bd = it.b_den;
        r  = '0;
        r.status = STAT_OK;
        if (it.func == FUNC_ADD || it.func == FUNC_SUB) begin
            if (ad == 0 || bd == 0) begin
                r.status = STAT_ZERO_DEN;
            end else begin
                // cross products fit in 64 bits; the sum is checked in 66
                p1  = an * bd;
                p2  = bn * ad;
                w1  = p1;
                w2  = p2;
                acc = (it.func == FUNC_ADD) ? w1 + w2 : w1 - w2;
                if (acc[65:63] != 3'b000 && acc[65:63] != 3'b111) begin
                    r.status = STAT_OVF;
                end else begin
                    r.res_num = acc[63:0];
                    r.res_den = ad * bd;
                end
            end
        end else if (ad == 0) begin
            r.status = STAT_ZERO_DEN;
        end else if (an == 0) begin
            r.res_den = 64'sd1;
        end else begin
            mag_n = (an < 0) ? -an : an;
            mag_d = (ad < 0) ? -ad : ad;
            if (mag_n == mag_d) begin
                r.res_num = ((an < 0) != (ad < 0)) ? -64'sd1 : 64'sd1;
                r.res_den = 64'sd1;
            end else begin
                x = mag_n;
                y = mag_d;
                while (y != 0) begin
                    t = x % y;
                    x = y;
                    y = t;
                end
                r.res_num = (an < 0) ? -(mag_n / x) : (mag_n / x);
                r.res_den = (ad < 0) ? -(mag_d / x) : (mag_d / x);
            end
        end
        return r;
    endfunction

    function automatic t_in_item make_item(logic [1:0] func,
                                           logic signed [31:0] a_num,
                                           logic signed [31:0] a_den,
                                           logic signed [31:0] b_num,
                                           logic signed [31:0] b_den);
        t_in_item it;
        it.func  = func;
        it.a_num = a_num;
        it.a_den = a_den;
        it.b_num = b_num;
        it.b_den = b_den;
        return it;
    endfunction

    // operand mix: full-range words, small values, the extremes, mid-size values
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(7))
            0, 1, 2: return $urandom;
            3, 4:    return int'($urandom_range(40)) - 20;
            5: begin
                case ($urandom_range(4))
                    0:       return 32'sd0;
                    1:       return 32'sd1;
                    2:       return -32'sd1;
                    3:       return 32'sh7fff_ffff;
                    default: return 32'sh8000_0000;
                endcase
            end
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    function automatic t_in_item random_item();
        t_in_item it;
        int       pick;
        int       factor;
        pick     = $urandom_range(15);
        it.func  = (pick < 6)  ? FUNC_ADD :
                   (pick < 11) ? FUNC_SUB :
                   (pick < 15) ? FUNC_SIMP : FUNC_SPARE;
        it.a_num = pick_operand();
        it.a_den = pick_operand();
        it.b_num = pick_operand();
        it.b_den = pick_operand();
        // half the reductions get a shared factor so the gcd is not trivially 1
        if (pick >= 11 && $urandom_range(1) == 1) begin
            factor   = $urandom_range(4095, 1);
            it.a_num = factor * (int'($urandom_range(60000)) - 30000);
            it.a_den = factor * (int'($urandom_range(60000)) - 30000);
        end
        return it;
    endfunction

    // drive one item at a falling edge after an optional random idle run,
    // hold it until taken, then log what the block must answer
    task automatic send_item(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        do @(posedge i_clk); while (o_stall);
        want = fraction_result(it);
        pending_results.push_back(want);
        items_sent++;
        if (it.func != FUNC_ADD && it.func != FUNC_SUB) simplify_sent++;
        if (want.status == STAT_ZERO_DEN) zero_den_seen++;
        if (want.status == STAT_OVF) overflow_seen++;
    endtask

    // sender goes quiet until every owed result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // checker: every taken result against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result num=%0d den=%0d status=%0d",
                             o_data.res_num, o_data.res_den, o_data.status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_data.res_num !== want.res_num || o_data.res_den !== want.res_den ||
                    o_data.status !== want.status) begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                                 want.res_num, want.res_den, want.status,
                                 o_data.res_num, o_data.res_den, o_data.status);
                    mismatches++;
                end
            end
        end
    end

    // plain sums and differences, small and at full width
    task automatic test_add_sub_basic();
        send_item(make_item(FUNC_ADD, 1, 2, 1, 3));
        send_item(make_item(FUNC_SUB, 1, 2, 1, 3));
        send_item(make_item(FUNC_SUB, 3, 4, 3, 4));
        send_item(make_item(FUNC_ADD, -5, 7, 2, -9));
        send_item(make_item(FUNC_ADD, 32'sh7fff_ffff, 32'sh7fff_ffff,
                            32'sh7fff_ffff, 32'sh7fff_ffff));
        send_item(make_item(FUNC_SUB, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7fff_ffff, 32'sh7fff_ffff));
        send_item(make_item(FUNC_SUB, 32'sh8000_0000, 32'sh7fff_ffff,
                            32'sh7fff_ffff, 32'sh8000_0000));
    endtask

    // zero denominator on either side, and for reduction
    task automatic test_zero_denominator();
        send_item(make_item(FUNC_ADD, 4, 0, 1, 3));
        send_item(make_item(FUNC_SUB, 4, 5, 1, 0));
        send_item(make_item(FUNC_SIMP, 0, 0, 1, 1));
        send_item(make_item(FUNC_SIMP, 7, 0, 9, 9));
    endtask

    // the one add that leaves 64 bits, and a near miss beside it
    task automatic test_overflow();
        send_item(make_item(FUNC_ADD, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 32'sh8000_0000));
        send_item(make_item(FUNC_ADD, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh7fff_ffff, 32'sh8000_0000));
    endtask

    // reduction: signs, zero numerator, equal magnitudes, extremes, spare selector
    task automatic test_simplify_cases();
        send_item(make_item(FUNC_SIMP, 6, 8, 0, 0));
        send_item(make_item(FUNC_SIMP, -6, 8, 0, 0));
        send_item(make_item(FUNC_SIMP, 6, -8, -1, -1));
        send_item(make_item(FUNC_SIMP, 0, -5, 3, 3));
        send_item(make_item(FUNC_SIMP, 5, 5, 0, 0));
        send_item(make_item(FUNC_SIMP, -5, 5, 0, 0));
        send_item(make_item(FUNC_SIMP, 32'sh8000_0000, 32'sh8000_0000, 0, 0));
        send_item(make_item(FUNC_SIMP, 32'sh8000_0000, 1, 0, 0));
        send_item(make_item(FUNC_SIMP, 1, 32'sh8000_0000, 0, 0));
        send_item(make_item(FUNC_SIMP, 32'sh8000_0000, 32'sh4000_0000, 0, 0));
        send_item(make_item(FUNC_SIMP, 32'sh7fff_ffff, 32'sh7fff_fffe, 0, 0));
        send_item(make_item(FUNC_SPARE, 12, 18, 32'sh7fff_ffff, 32'sh8000_0000));
    endtask

    // random traffic under one idle/stall mix, ending with a full drain
    task automatic test_random_traffic(input int sender_idle, input int receiver_stall,
                                       input int count);
        idle_pct  = sender_idle;
        stall_pct = receiver_stall;
        repeat (count) send_item(random_item());
        drain_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data        = '0;
        idle_pct      = 0;
        stall_pct     = 0;
        mismatches    = 0;
        results_seen  = 0;
        items_sent    = 0;
        simplify_sent = 0;
        zero_den_seen = 0;
        overflow_seen = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, back to back
        test_add_sub_basic();
        test_zero_denominator();
        test_overflow();
        test_simplify_cases();
        drain_results();

        // random traffic: no idling, busy sender gaps, heavy back-pressure, a mix
        test_random_traffic(0, 0, 150);
        test_random_traffic(84, 0, 150);
        test_random_traffic(0, 84, 150);
        test_random_traffic(25, 25, 150);

        // let any late result show up, then account for what is still owed
        stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            mismatches += pending_results.size();
        end

        $display("sent %0d items (%0d reductions), %0d zero-denominator, %0d overflow",
                 items_sent, simplify_sent, zero_den_seen, overflow_seen);
        $display("checked %0d results, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
design/fasr_pkg.sv
design/fasr_sub_unit.sv
design/fraction_add_sub_reduce.sv
dv/fraction_add_sub_reduce_tb.sv
